// File: rtl/tbwp_pkg.sv
package tbwp_pkg;

   localparam int unsigned VRAM_BYTES  = 8192;
   localparam int unsigned VRAM_ADDR_W = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COORD_W     = 8;
   localparam int unsigned SHADE_W     = 2;
   localparam int unsigned CSR_INDEX_W = 3;

   // Request kinds.
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LCD_CONTROL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HSCROLL     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VSCROLL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_LEFT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIN_TOP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_PALETTE  = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] LCD_CONTROL_RESET = 8'h91;
   localparam logic [BYTE_W-1:0] BG_PALETTE_RESET  = 8'hFC;

   // Bit positions inside lcd_control.
   localparam int unsigned LCDC_BG_EN   = 0;
   localparam int unsigned LCDC_BG_MAP  = 3;
   localparam int unsigned LCDC_TILE_LO = 4;
   localparam int unsigned LCDC_WIN_EN  = 5;
   localparam int unsigned LCDC_WIN_MAP = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_LO,
      ST_HI,
      ST_SHADE,
      ST_DONE
   } state_type;

   // Position of a pixel inside a layer: tile column and row, pixel inside the tile.
   typedef struct packed {
      logic [4:0] col;
      logic [4:0] row;
      logic [2:0] px;
      logic [2:0] py;
   } layer_pos_type;

   typedef struct packed {
      logic [SHADE_W-1:0] bg_shade;
      logic               bg_visible;
      logic [SHADE_W-1:0] win_shade;
      logic               win_visible;
   } pixel_result_type;

   // Tile map entry: maps sit at offsets 0x1800 and 0x1C00, 32 by 32 entries.
   function automatic logic [VRAM_ADDR_W-1:0] map_addr(input logic sel,
                                                       input layer_pos_type pos);
      map_addr = {2'b11, sel, pos.row, pos.col};
   endfunction

   // Bitplane byte of a tile row. In signed mode the tile number is offset from
   // 0x1000, which gives the same layout as unsigned mode except for bit 12.
   function automatic logic [VRAM_ADDR_W-1:0] tile_addr(input logic unsigned_mode,
                                                        input logic [BYTE_W-1:0] id,
                                                        input logic [2:0] py,
                                                        input logic plane);
      tile_addr = {~unsigned_mode & ~id[7], id, py, plane};
   endfunction

   function automatic logic [SHADE_W-1:0] pixel_shade(input logic [BYTE_W-1:0] lo,
                                                      input logic [BYTE_W-1:0] hi,
                                                      input logic [2:0] px,
                                                      input logic [BYTE_W-1:0] pal);
      logic [1:0] code;
      code        = {hi[~px], lo[~px]};
      pixel_shade = pal[{code, 1'b0} +: SHADE_W];
   endfunction

endpackage

// File: rtl/tbwp_if.sv
interface tbwp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic [tbwp_pkg::VRAM_ADDR_W-1:0]     vram_addr;
   logic [tbwp_pkg::BYTE_W-1:0]          vram_data;
   logic [tbwp_pkg::COORD_W-1:0]         pixel_x;
   logic [tbwp_pkg::COORD_W-1:0]         line;

   modport source (output valid, req_type, vram_addr, vram_data, pixel_x, line,
                   input ready);
   modport sink (input valid, req_type, vram_addr, vram_data, pixel_x, line,
                 output ready);
   modport monitor (input valid, ready, req_type, vram_addr, vram_data, pixel_x, line);
endinterface

interface tbwp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tbwp_pkg::SHADE_W-1:0]      bg_shade;
   logic                              bg_visible;
   logic [tbwp_pkg::SHADE_W-1:0]      win_shade;
   logic                              win_visible;

   modport source (output valid, bg_shade, bg_visible, win_shade, win_visible,
                   input ready);
   modport sink (input valid, bg_shade, bg_visible, win_shade, win_visible,
                 output ready);
   modport monitor (input valid, ready, bg_shade, bg_visible, win_shade, win_visible);
endinterface

// File: rtl/tile_background_window_pixel_core.sv
// Background and window pixel generator over an 8 KiB video RAM. A write request
// stores one byte; the block is ready again at once. A render request returns one
// response with the palette-mapped shade of the background and of the window at
// (pixel_x, line). Rendering a layer costs three reads of the video RAM (tile
// map entry, low bitplane, high bitplane) through its registered read port, in
// states MAP, LO and HI, then forms the shade in SHADE; a render request keeps
// the block busy through these states for each layer shown and then DONE, or
// only DONE when neither layer covers the pixel. The finished response sits in
// an output register, so the next request is taken while it waits. There is no
// clearing pass after reset: video RAM holds whatever was last written, and bytes
// never written read as anything. The user must write configuration through the
// csr_ port only while the block is idle; the block does not enforce this.
module tile_background_window_pixel_core #(
   parameter int unsigned SCREEN_WIDTH = 160
) (
   input  logic                                clock,
   input  logic                                reset,
   tbwp_req_if.sink                            req_chan,
   tbwp_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [tbwp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbwp_pkg::BYTE_W-1:0]         csr_wdata
);

   // Configuration registers.
   logic [tbwp_pkg::BYTE_W-1:0] lcd_control_ff;
   logic [tbwp_pkg::BYTE_W-1:0] hscroll_ff;
   logic [tbwp_pkg::BYTE_W-1:0] vscroll_ff;
   logic [tbwp_pkg::BYTE_W-1:0] win_left_ff;
   logic [tbwp_pkg::BYTE_W-1:0] win_top_ff;
   logic [tbwp_pkg::BYTE_W-1:0] bg_palette_ff;

   // Sequencer and working registers.
   tbwp_pkg::state_type         state_ff, state_in;
   logic                        layer_ff;      // low for background, high for window
   logic                        win_act_ff;
   tbwp_pkg::layer_pos_type     bg_pos_ff;
   tbwp_pkg::layer_pos_type     win_pos_ff;
   logic [tbwp_pkg::BYTE_W-1:0] id_ff;
   logic [tbwp_pkg::BYTE_W-1:0] lo_ff;
   tbwp_pkg::pixel_result_type  work_ff;
   tbwp_pkg::pixel_result_type  out_ff;
   logic                        rsp_valid_ff;

   // Video RAM with a registered read port.
   logic [tbwp_pkg::BYTE_W-1:0]      vram_mem [tbwp_pkg::VRAM_BYTES];
   logic [tbwp_pkg::BYTE_W-1:0]      rd_data_ff;
   logic [tbwp_pkg::VRAM_ADDR_W-1:0] rd_addr;
   logic                             mem_we;

   logic                        req_accept;
   logic                        render_accept;
   logic                        out_load;
   logic                        on_screen;
   logic                        bg_en;
   logic                        win_en;
   logic [tbwp_pkg::BYTE_W-1:0] map_x;
   logic [tbwp_pkg::BYTE_W-1:0] map_y;
   logic [8:0]                  win_x9;
   logic [8:0]                  x_plus7;
   logic [tbwp_pkg::BYTE_W-1:0] win_y;
   tbwp_pkg::layer_pos_type     cur_pos;
   logic                        cur_map_sel;
   logic [tbwp_pkg::SHADE_W-1:0] cur_shade;

   assign req_accept    = req_chan.valid && req_chan.ready;
   assign render_accept = req_accept && (req_chan.req_type == tbwp_pkg::REQ_RENDER);
   assign mem_we        = req_accept && (req_chan.req_type == tbwp_pkg::REQ_WRITE);
   assign out_load      = (state_ff == tbwp_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Layer coverage and in-layer coordinates, worked out from the request.
   always_comb begin
      on_screen = {1'b0, req_chan.pixel_x} < 9'(SCREEN_WIDTH);
      map_x     = req_chan.pixel_x + hscroll_ff;
      map_y     = req_chan.line + vscroll_ff;
      x_plus7   = {1'b0, req_chan.pixel_x} + 9'd7;
      win_x9    = x_plus7 - {1'b0, win_left_ff};
      win_y     = req_chan.line - win_top_ff;
      bg_en     = lcd_control_ff[tbwp_pkg::LCDC_BG_EN] && on_screen;
      win_en    = lcd_control_ff[tbwp_pkg::LCDC_WIN_EN] && on_screen &&
                  (req_chan.line >= win_top_ff) && (x_plus7 >= {1'b0, win_left_ff});
   end

   // The layer being fetched selects its map and its position.
   always_comb begin
      cur_pos     = layer_ff ? win_pos_ff : bg_pos_ff;
      cur_map_sel = layer_ff ? lcd_control_ff[tbwp_pkg::LCDC_WIN_MAP]
                             : lcd_control_ff[tbwp_pkg::LCDC_BG_MAP];
      cur_shade   = tbwp_pkg::pixel_shade(lo_ff, rd_data_ff, cur_pos.px, bg_palette_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbwp_pkg::ST_IDLE: begin
            if (render_accept) begin
               if (bg_en || win_en) begin
                  state_in = tbwp_pkg::ST_MAP;
               end else begin
                  state_in = tbwp_pkg::ST_DONE;
               end
            end
         end
         tbwp_pkg::ST_MAP: begin
            state_in = tbwp_pkg::ST_LO;
         end
         tbwp_pkg::ST_LO: begin
            state_in = tbwp_pkg::ST_HI;
         end
         tbwp_pkg::ST_HI: begin
            state_in = tbwp_pkg::ST_SHADE;
         end
         tbwp_pkg::ST_SHADE: begin
            if (!layer_ff && win_act_ff) begin
               state_in = tbwp_pkg::ST_MAP;
            end else begin
               state_in = tbwp_pkg::ST_DONE;
            end
         end
         tbwp_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = tbwp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbwp_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: request ready and the video RAM read address.
   // The low bitplane address is formed straight from the tile number on the
   // read port, so the fetches follow one another without a gap.
   always_comb begin
      req_chan.ready = 1'b0;
      rd_addr        = '0;
      case (state_ff)
         tbwp_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         tbwp_pkg::ST_MAP: begin
            rd_addr = tbwp_pkg::map_addr(cur_map_sel, cur_pos);
         end
         tbwp_pkg::ST_LO: begin
            rd_addr = tbwp_pkg::tile_addr(lcd_control_ff[tbwp_pkg::LCDC_TILE_LO],
                                          rd_data_ff, cur_pos.py, 1'b0);
         end
         tbwp_pkg::ST_HI: begin
            rd_addr = tbwp_pkg::tile_addr(lcd_control_ff[tbwp_pkg::LCDC_TILE_LO],
                                          id_ff, cur_pos.py, 1'b1);
         end
         tbwp_pkg::ST_SHADE: begin
            rd_addr = '0;
         end
         tbwp_pkg::ST_DONE: begin
            rd_addr = '0;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram_mem[req_chan.vram_addr] <= req_chan.vram_data;
      end
      rd_data_ff <= vram_mem[rd_addr];
   end

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_control_ff <= tbwp_pkg::LCD_CONTROL_RESET;
         hscroll_ff     <= '0;
         vscroll_ff     <= '0;
         win_left_ff    <= '0;
         win_top_ff     <= '0;
         bg_palette_ff  <= tbwp_pkg::BG_PALETTE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tbwp_pkg::CSR_LCD_CONTROL: begin
               lcd_control_ff <= csr_wdata;
            end
            tbwp_pkg::CSR_HSCROLL: begin
               hscroll_ff <= csr_wdata;
            end
            tbwp_pkg::CSR_VSCROLL: begin
               vscroll_ff <= csr_wdata;
            end
            tbwp_pkg::CSR_WIN_LEFT: begin
               win_left_ff <= csr_wdata;
            end
            tbwp_pkg::CSR_WIN_TOP: begin
               win_top_ff <= csr_wdata;
            end
            tbwp_pkg::CSR_BG_PALETTE: begin
               bg_palette_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbwp_pkg::ST_IDLE;
         layer_ff     <= 1'b0;
         win_act_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (render_accept) begin
            // Without a background the fetch starts on the window.
            layer_ff   <= !bg_en;
            win_act_ff <= win_en;
         end else if (state_ff == tbwp_pkg::ST_SHADE) begin
            layer_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (render_accept) begin
         bg_pos_ff  <= '{col: map_x[7:3], row: map_y[7:3], px: map_x[2:0], py: map_y[2:0]};
         win_pos_ff <= '{col: win_x9[7:3], row: win_y[7:3], px: win_x9[2:0], py: win_y[2:0]};
         work_ff    <= '0;
      end
      if (state_ff == tbwp_pkg::ST_LO) begin
         id_ff <= rd_data_ff;
      end
      if (state_ff == tbwp_pkg::ST_HI) begin
         lo_ff <= rd_data_ff;
      end
      if (state_ff == tbwp_pkg::ST_SHADE) begin
         if (layer_ff) begin
            work_ff.win_shade   <= cur_shade;
            work_ff.win_visible <= 1'b1;
         end else begin
            work_ff.bg_shade   <= cur_shade;
            work_ff.bg_visible <= 1'b1;
         end
      end
      if (out_load) begin
         out_ff <= work_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bg_shade    = out_ff.bg_shade;
   assign rsp_chan.bg_visible  = out_ff.bg_visible;
   assign rsp_chan.win_shade   = out_ff.win_shade;
   assign rsp_chan.win_visible = out_ff.win_visible;

endmodule

// File: rtl/tbwp_checker.sv
module tbwp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_type,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tbwp_pkg::SHADE_W-1:0] rsp_bg_shade,
   input logic                         rsp_bg_visible,
   input logic [tbwp_pkg::SHADE_W-1:0] rsp_win_shade,
   input logic                         rsp_win_visible
);

   // No response is offered straight after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered straight after reset");

   // A response that is not taken keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_bg_shade) && $stable(rsp_bg_visible) &&
         $stable(rsp_win_shade) && $stable(rsp_win_visible))
      else $error("stalled response changed");

   // A layer that is not shown reports a shade of zero.
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bg_visible || rsp_bg_shade == '0) &&
                    (rsp_win_visible || rsp_win_shade == '0))
      else $error("hidden layer with non-zero shade");

   // A render request keeps the block busy for at least the following cycle.
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == tbwp_pkg::REQ_RENDER) |=> !req_ready)
      else $error("request taken while a render is in progress");

endmodule

bind tile_background_window_pixel_core tbwp_checker u_tbwp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_type        (req_chan.req_type),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bg_shade    (rsp_chan.bg_shade),
   .rsp_bg_visible  (rsp_chan.bg_visible),
   .rsp_win_shade   (rsp_chan.win_shade),
   .rsp_win_visible (rsp_chan.win_visible)
);
